### rtl/core/mmn_pkg.sv
`timescale 1ns / 1ps

package mmn_pkg;

	// fixed width of the pixel port
	localparam int unsigned PIXEL_PORT_W   = 31;
	// default for the number of pixel bits in use
	localparam int unsigned PIXEL_BITS_DEF = 31;
	// width of the scaled output
	localparam int unsigned QUO_BITS       = 8;
	localparam logic [QUO_BITS-1:0] OUT_MAX = 8'd255;
	localparam logic [QUO_BITS-1:0] OUT_MIN = 8'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_DONE
	} state_t;

	localparam logic CMD_SCAN      = 1'b0;
	localparam logic CMD_NORMALIZE = 1'b1;

endpackage

### rtl/core/mmn_range.sv
`timescale 1ns / 1ps

module mmn_range #(
	parameter int unsigned PIXEL_BITS = mmn_pkg::PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  upd,
	input  logic                  first,
	input  logic [PIXEL_BITS-1:0] pix,
	output logic [PIXEL_BITS-1:0] min_seen,
	output logic [PIXEL_BITS-1:0] max_seen
);

	logic [PIXEL_BITS-1:0] min_q;
	logic [PIXEL_BITS-1:0] max_q;
	logic [PIXEL_BITS-1:0] base_min;
	logic [PIXEL_BITS-1:0] base_max;

	// first item of an image starts from the empty range
	always_comb begin
		base_min = first ? {PIXEL_BITS{1'b1}} : min_q;
		base_max = first ? {PIXEL_BITS{1'b0}} : max_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= {PIXEL_BITS{1'b1}};
			max_q <= {PIXEL_BITS{1'b0}};
		end else if (upd) begin
			min_q <= (pix < base_min) ? pix : base_min;
			max_q <= (pix > base_max) ? pix : base_max;
		end
	end

	assign min_seen = min_q;
	assign max_seen = max_q;

endmodule

### rtl/core/mmn_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit a cycle; the numerator's upper part
// must be below the divisor so the quotient fits in QUO_BITS
module mmn_div #(
	parameter int unsigned W = mmn_pkg::PIXEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [W+mmn_pkg::QUO_BITS-1:0]      num,
	input  logic [W-1:0]                        den,
	output logic                                done,
	output logic [mmn_pkg::QUO_BITS-1:0]        quotient
);

	localparam int unsigned QB    = mmn_pkg::QUO_BITS;
	localparam int unsigned CNT_W = $clog2(QB);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     den_q;
	logic [QB-1:0]    low_q;
	logic [QB-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       trial;
	logic [W:0]       diff;
	logic             fits;

	always_comb begin
		trial = {rem_q, low_q[QB-1]};
		diff  = trial - {1'b0, den_q};
		fits  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QB - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[W+QB-1:QB];
			low_q <= num[QB-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			low_q <= {low_q[QB-2:0], 1'b0};
			quo_q <= {quo_q[QB-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/core/min_max_pixel_normalizer_unit.sv
`timescale 1ns / 1ps

// min-max normaliser to 8 bits, two passes over an image
// input channel in_valid/in_ready carries cmd, pixel and first_of_image;
// cmd scan folds the pixel into the stored min and max (first_of_image
// restarts the range), cmd normalize yields one item on the output channel
// out_valid/out_ready: normalized = floor((pixel-min)*255/(max-min)),
// with flat_range and clipped flags.
// a scan item is taken while the unit is idle and another can follow at once.
// a normalize item inside the range passes from acceptance to out_valid
// through the setup state for the range checks and the numerator, the div
// state, in which the bit-serial restoring divider runs and its quotient
// is collected, and the done state, which loads the output register.
// in_ready is low over that span and returns with the load, so no new
// item is taken before the last normalize result has been loaded. a flat
// or clipped item skips the divider and goes from setup straight to done.
// the output register holds a result until out_ready; a new item is still
// accepted meanwhile, and a finished normalize waits in its done state if
// the output register is still full.
// reset sets the stored range to empty (min all ones, max zero) and drops
// any pending result; no clearing pass is needed.
module min_max_pixel_normalizer_unit #(
	parameter int unsigned PIXEL_BITS = mmn_pkg::PIXEL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [mmn_pkg::PIXEL_PORT_W-1:0]  pixel,
	input  logic                              first_of_image,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mmn_pkg::QUO_BITS-1:0]      normalized,
	output logic                              flat_range,
	output logic                              clipped
);

	localparam int unsigned QB = mmn_pkg::QUO_BITS;

	mmn_pkg::state_t state_q;
	mmn_pkg::state_t state_nxt;

	logic                  in_acc;
	logic                  scan_acc;
	logic                  norm_acc;
	logic [PIXEL_BITS-1:0] pix_in;
	logic [PIXEL_BITS-1:0] pix_q;
	logic [PIXEL_BITS-1:0] min_seen;
	logic [PIXEL_BITS-1:0] max_seen;

	logic                  flat;
	logic                  below;
	logic                  above;
	logic [PIXEL_BITS-1:0] pix_off;
	logic [PIXEL_BITS-1:0] span;
	logic [PIXEL_BITS+QB-1:0] num;

	logic          div_start;
	logic          div_done;
	logic [QB-1:0] div_quo;
	logic          out_load;

	logic [QB-1:0] res_norm_q;
	logic          res_flat_q;
	logic          res_clip_q;
	logic [QB-1:0] out_norm_q;
	logic          out_flat_q;
	logic          out_clip_q;
	logic          out_valid_q;

	assign pix_in   = pixel[PIXEL_BITS-1:0];
	assign in_acc   = in_valid & in_ready;
	assign scan_acc = in_acc & (cmd == mmn_pkg::CMD_SCAN);
	assign norm_acc = in_acc & (cmd == mmn_pkg::CMD_NORMALIZE);

	mmn_range #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_range (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (scan_acc),
		.first    (first_of_image),
		.pix      (pix_in),
		.min_seen (min_seen),
		.max_seen (max_seen)
	);

	// range checks and numerator (pix_off*255 as pix_off*256 - pix_off)
	always_comb begin
		flat    = (max_seen <= min_seen);
		below   = (pix_q < min_seen);
		above   = (pix_q > max_seen);
		pix_off = pix_q - min_seen;
		span    = max_seen - min_seen;
		num     = {pix_off, {QB{1'b0}}} - {{QB{1'b0}}, pix_off};
	end

	mmn_div #(
		.W(PIXEL_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num),
		.den      (span),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mmn_pkg::ST_IDLE: begin
				if (norm_acc) state_nxt = mmn_pkg::ST_SETUP;
			end
			mmn_pkg::ST_SETUP: begin
				state_nxt = (flat | below | above) ? mmn_pkg::ST_DONE : mmn_pkg::ST_DIV;
			end
			mmn_pkg::ST_DIV: begin
				if (div_done) state_nxt = mmn_pkg::ST_DONE;
			end
			mmn_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) state_nxt = mmn_pkg::ST_IDLE;
			end
			default: state_nxt = mmn_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == mmn_pkg::ST_IDLE);
		div_start = (state_q == mmn_pkg::ST_SETUP) & ~(flat | below | above);
		out_load  = (state_q == mmn_pkg::ST_DONE) & (~out_valid_q | out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mmn_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (norm_acc) begin
			pix_q <= pix_in;
		end
		if (state_q == mmn_pkg::ST_SETUP) begin
			res_flat_q <= flat;
			res_clip_q <= below | above;
			if (flat || below) begin
				res_norm_q <= mmn_pkg::OUT_MIN;
			end else begin
				res_norm_q <= mmn_pkg::OUT_MAX;
			end
		end else if (state_q == mmn_pkg::ST_DIV && div_done) begin
			res_norm_q <= div_quo;
		end
		if (out_load) begin
			out_norm_q <= res_norm_q;
			out_flat_q <= res_flat_q;
			out_clip_q <= res_clip_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign normalized = out_norm_q;
	assign flat_range = out_flat_q;
	assign clipped    = out_clip_q;

	// a normalize item blocks the input until its result is loaded
	a_norm_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		norm_acc |=> !in_ready)
		else $error("input taken while a normalize item is in flight");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == mmn_pkg::ST_DIV))
		else $error("divider finished outside its state");

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && flat_range) |-> (normalized == mmn_pkg::OUT_MIN))
		else $error("flat range item without zero result");

	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped && !flat_range) |->
		(normalized == mmn_pkg::OUT_MIN || normalized == mmn_pkg::OUT_MAX))
		else $error("clipped item not saturated");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(normalized))
		else $error("pending result overwritten");

endmodule

### test/min_max_pixel_normalizer_checker.sv
`timescale 1ns / 1ps

module min_max_pixel_normalizer_checker #(
	parameter int unsigned PIXEL_BITS = mmn_pkg::PIXEL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              cmd,
	input  logic [mmn_pkg::PIXEL_PORT_W-1:0]  pixel,
	input  logic                              first_of_image,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [mmn_pkg::QUO_BITS-1:0]      normalized,
	input  logic                              flat_range,
	input  logic                              clipped,
	output int unsigned                       fail_count,
	output int unsigned                       pending
);
	import mmn_pkg::*;

	typedef struct packed {
		logic [QUO_BITS-1:0] norm;
		logic                flat;
		logic                clip;
	} scaled_t;

	localparam logic [PIXEL_PORT_W-1:0] PIX_MASK  = {PIXEL_PORT_W{1'b1}} >> (PIXEL_PORT_W - PIXEL_BITS);
	localparam logic [PIXEL_PORT_W-1:0] EMPTY_MIN = '1;

	logic [PIXEL_PORT_W-1:0] lo_seen;
	logic [PIXEL_PORT_W-1:0] hi_seen;
	scaled_t                 scaled_q[$];
	int unsigned             mismatches = 0;
	int unsigned             waiting = 0;

	assign fail_count = mismatches;
	assign pending    = waiting;

	function automatic scaled_t scale_pixel(input logic [PIXEL_PORT_W-1:0] p,
			input logic [PIXEL_PORT_W-1:0] lo, input logic [PIXEL_PORT_W-1:0] hi);
		scaled_t    r = '0;
		logic [63:0] num;
		logic [63:0] den;
		r.clip = (p < lo) || (p > hi);
		if (hi <= lo) begin
			// empty or single-value range
			r.flat = 1'b1;
			r.norm = OUT_MIN;
		end else if (p < lo) begin
			r.norm = OUT_MIN;
		end else if (p > hi) begin
			r.norm = OUT_MAX;
		end else begin
			num    = (64'(p) - 64'(lo)) * 64'(OUT_MAX);
			den    = 64'(hi) - 64'(lo);
			r.norm = QUO_BITS'(num / den);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [PIXEL_PORT_W-1:0] p;
		logic [PIXEL_PORT_W-1:0] lo;
		logic [PIXEL_PORT_W-1:0] hi;
		scaled_t                 want;
		scaled_t                 got;
		if (!arst_n) begin
			lo_seen <= EMPTY_MIN;
			hi_seen <= '0;
			scaled_q.delete();
			waiting <= 0;
		end else begin
			// results first, so an item taken at this edge cannot match itself
			if (out_valid && out_ready) begin
				got = {normalized, flat_range, clipped};
				if (scaled_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("%0t: unexpected result norm=%0d flat=%0b clip=%0b",
							$realtime, got.norm, got.flat, got.clip);
				end else begin
					want = scaled_q.pop_front();
					if (want != got) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("%0t: result mismatch expected norm=%0d flat=%0b clip=%0b, got norm=%0d flat=%0b clip=%0b",
								$realtime, want.norm, want.flat, want.clip,
								got.norm, got.flat, got.clip);
					end
				end
			end
			if (in_valid && in_ready) begin
				p = pixel & PIX_MASK;
				if (cmd == CMD_SCAN) begin
					lo = first_of_image ? EMPTY_MIN : lo_seen;
					hi = first_of_image ? '0 : hi_seen;
					if (p < lo)
						lo = p;
					if (p > hi)
						hi = p;
					lo_seen <= lo;
					hi_seen <= hi;
				end else begin
					scaled_q.push_back(scale_pixel(p, lo_seen, hi_seen));
				end
			end
			waiting <= scaled_q.size();
		end
	end

endmodule

### test/min_max_pixel_normalizer_unit_tb.sv
`timescale 1ns / 1ps

module min_max_pixel_normalizer_unit_tb;
	import mmn_pkg::*;

	localparam int unsigned PIX_BITS    = PIXEL_BITS_DEF;
	localparam int unsigned ITEM_TARGET = 1900;
	localparam int unsigned QUIET_ITEMS = 250;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    cmd = CMD_SCAN;
	logic [PIXEL_PORT_W-1:0] pixel = '0;
	logic                    first_of_image = 1'b0;
	logic                    out_ready = 1'b0;
	wire                     in_ready;
	wire                     out_valid;
	wire  [QUO_BITS-1:0]     normalized;
	wire                     flat_range;
	wire                     clipped;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned items_sent = 0;
	int unsigned cycles = 0;
	int unsigned in_gap_odds = 8;
	int unsigned out_calm = 0;
	bit          quiet = 1'b0;

	min_max_pixel_normalizer_unit #(
		.PIXEL_BITS(PIX_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.pixel(pixel),
		.first_of_image(first_of_image),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.normalized(normalized),
		.flat_range(flat_range),
		.clipped(clipped)
	);

	min_max_pixel_normalizer_checker #(
		.PIXEL_BITS(PIX_BITS)
	) range_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.pixel(pixel),
		.first_of_image(first_of_image),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.normalized(normalized),
		.flat_range(flat_range),
		.clipped(clipped),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// output stalls in bursts, with calm stretches now and then
	initial begin
		forever begin
			if (!quiet && out_calm == 0 && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ready <= 1'b1;
			if (out_calm != 0)
				out_calm--;
			else if ($urandom_range(0, 99) == 0)
				out_calm = $urandom_range(20, 80);
			@(posedge clk);
		end
	end

	task automatic put_pixel(input logic c, input logic [PIXEL_PORT_W-1:0] p, input logic f);
		if (!quiet && in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		cmd            <= c;
		pixel          <= p;
		first_of_image <= f;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	// hold the sender off until every normalize item has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [PIXEL_PORT_W-1:0] pick_in_range(
			input logic [PIXEL_PORT_W-1:0] lo, input logic [PIXEL_PORT_W-1:0] hi);
		logic [63:0] span;
		if (hi < lo)
			return PIXEL_PORT_W'($urandom);
		span = 64'(hi) - 64'(lo) + 64'd1;
		return PIXEL_PORT_W'(64'(lo) + ({$urandom, $urandom} % span));
	endfunction

	initial begin
		logic [PIXEL_PORT_W-1:0] img_lo;
		logic [PIXEL_PORT_W-1:0] img_hi;
		logic [PIXEL_PORT_W-1:0] base;
		logic [PIXEL_PORT_W-1:0] p;
		logic                    f;
		int unsigned             span;
		int unsigned             n;
		int unsigned             m;
		int unsigned             kind;
		int unsigned             img_count;
		bit                      mid_drained;
		img_lo      = '1;
		img_hi      = '0;
		img_count   = 0;
		mid_drained = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// normalize before any scan: empty range
		put_pixel(CMD_NORMALIZE, 31'h0000_1234, 1'b0);
		// full-scale range
		put_pixel(CMD_SCAN, 31'h0000_0000, 1'b1);
		put_pixel(CMD_SCAN, 31'h7FFF_FFFF, 1'b0);
		put_pixel(CMD_NORMALIZE, 31'h0000_0000, 1'b0);
		put_pixel(CMD_NORMALIZE, 31'h7FFF_FFFF, 1'b0);
		put_pixel(CMD_NORMALIZE, 31'h4000_0000, 1'b1);
		put_pixel(CMD_NORMALIZE, 31'h2AAA_AAAA, 1'b0);
		// single-value image
		put_pixel(CMD_SCAN, 31'd100, 1'b1);
		put_pixel(CMD_NORMALIZE, 31'd100, 1'b0);
		put_pixel(CMD_NORMALIZE, 31'd99, 1'b0);
		put_pixel(CMD_NORMALIZE, 31'd101, 1'b1);
		// narrow range, below and above
		put_pixel(CMD_SCAN, 31'd1000, 1'b1);
		put_pixel(CMD_SCAN, 31'd2000, 1'b0);
		put_pixel(CMD_NORMALIZE, 31'd999, 1'b0);
		put_pixel(CMD_NORMALIZE, 31'd2001, 1'b0);
		put_pixel(CMD_NORMALIZE, 31'd1000, 1'b0);
		put_pixel(CMD_NORMALIZE, 31'd2000, 1'b0);
		put_pixel(CMD_NORMALIZE, 31'd1500, 1'b0);
		// range grows without a restart
		put_pixel(CMD_SCAN, 31'd500, 1'b0);
		put_pixel(CMD_NORMALIZE, 31'd500, 1'b0);
		put_pixel(CMD_NORMALIZE, 31'd1999, 1'b0);
		// single value at the top
		put_pixel(CMD_SCAN, 31'h7FFF_FFFF, 1'b1);
		put_pixel(CMD_NORMALIZE, 31'h0000_0000, 1'b0);
		drain_results();

		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= ITEM_TARGET - QUIET_ITEMS)
				quiet = 1'b1;
			if (!mid_drained && items_sent >= ITEM_TARGET / 2) begin
				drain_results();
				mid_drained = 1'b1;
			end
			in_gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
			n    = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 24);
			kind = $urandom_range(0, 3);
			base = (kind == 1) ? PIXEL_PORT_W'($urandom_range(0, 32'h7FFF_FEC0))
				: PIXEL_PORT_W'($urandom);
			span = $urandom_range(0, 300);

			for (int i = 0; i < n; i++) begin
				if (i == 0)
					f = (img_count == 0) || ($urandom_range(0, 9) != 0);
				else
					f = ($urandom_range(0, 29) == 0);
				case (kind)
					0: p = PIXEL_PORT_W'($urandom);
					1: p = pick_in_range(base, base + PIXEL_PORT_W'(span));
					2: p = base;
					default: begin
						if ($urandom_range(0, 2) == 0)
							p = '1;
						else if ($urandom_range(0, 1) == 0)
							p = '0;
						else
							p = PIXEL_PORT_W'($urandom_range(0, 255));
					end
				endcase
				if (f) begin
					img_lo = '1;
					img_hi = '0;
				end
				if (p < img_lo)
					img_lo = p;
				if (p > img_hi)
					img_hi = p;
				put_pixel(CMD_SCAN, p, f);
			end
			img_count++;

			m = $urandom_range(1, 30);
			for (int j = 0; j < m; j++) begin
				case ($urandom_range(0, 9))
					0: p = PIXEL_PORT_W'($urandom);
					1: begin
						// just outside the stored range
						if ($urandom_range(0, 1) == 0 && img_lo != '0 && img_lo <= img_hi)
							p = img_lo - 1'b1;
						else if (img_hi != '1)
							p = img_hi + 1'b1;
						else
							p = PIXEL_PORT_W'($urandom);
					end
					default: p = pick_in_range(img_lo, img_hi);
				endcase
				put_pixel(CMD_NORMALIZE, p, 1'($urandom));
			end
		end

		drain_results();
		repeat (30) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
